### rtl/psess_pkg.sv
// Shared types and constants for the peer session table.
package psess_pkg;

  localparam int unsigned PEER_SLOTS = 16;
  localparam int unsigned SLOT_IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int unsigned MASK_W     = 16;

  localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

  // Event kinds carried in the op field; other codes behave as a tick.
  localparam logic [2:0] OP_CONNECT    = 3'd0;
  localparam logic [2:0] OP_HEARTBEAT  = 3'd1;
  localparam logic [2:0] OP_DISCONNECT = 3'd2;
  localparam logic [2:0] OP_DATA       = 3'd3;
  localparam logic [2:0] OP_TICK       = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic [4:0] NO_PEER = 5'h1F;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FINISH
  } seq_state_e;

  // One slot entry as stored in the table memory.
  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] last_heard;
  } slot_ent_t;

endpackage

### rtl/psess_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module psess_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/peer_session_table_core.sv
// Top level of the peer session table: event sequencer around the slot memory.
//
// Usage: each input transaction on in_valid_i/in_ready_o carries one classified
// event (connect, heartbeat, disconnect, data or tick) with the current time in
// milliseconds. Every event produces exactly one output transaction on
// out_valid_o/out_ready_i carrying peer_id, status, send_ack, the accepted length
// and the mask of slots dropped by the idle timeout.
// Slot keys and timestamps live in a single synchronous RAM with a registered
// read port; the valid bits are flip-flops. An event walks all PEER_SLOTS
// entries, one read per cycle, matching the key, picking the lowest free slot
// and aging every valid slot in the same pass. S_LAST then drains the read
// pipeline and S_FINISH writes back the claimed or refreshed entry and loads the
// result register; a new event is only accepted once the sequencer is idle again.
// The result register decouples the two sides: the next event is accepted while
// a result still waits; it holds in its final step until the result is taken.
// Reset clears all valid bits and restores the timeout to 10000 ms; the memory
// itself needs no clearing since an entry is only used while its slot is valid.
// The timeout register is written through cfg_we_i/cfg_wdata_i. The user must
// write it only while idle; the block itself does not enforce this.
module peer_session_table_core
  import psess_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        op_i,
  input  logic [31:0]       src_ip_i,
  input  logic [15:0]       src_port_i,
  input  logic [15:0]       dgram_len_i,
  input  logic [31:0]       now_ms_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [4:0] peer_id_o,
  output logic [1:0]        status_o,
  output logic              send_ack_o,
  output logic [15:0]       rx_len_o,
  output logic [15:0]       expired_mask_o
);

  // Slot index to the 5-bit peer id; higher slot numbers alias by truncation.
  function automatic logic [4:0] slot_to_pid(input logic [SLOT_IDX_W-1:0] s);
    logic [SLOT_IDX_W+4:0] w;
    w = {5'b0, s};
    return w[4:0];
  endfunction

  seq_state_e state_q, state_d;

  logic [31:0] timeout_q;

  // Latched event.
  logic [2:0]  op_q;
  logic [31:0] ip_q;
  logic [15:0] port_q;
  logic [15:0] plen_q;
  logic [31:0] now_q;

  // Scan bookkeeping.
  logic [SLOT_IDX_W-1:0] cnt_q;
  logic                  cmp_vld_q;
  logic [SLOT_IDX_W-1:0] cmp_idx_q;
  logic                  found_q;
  logic [SLOT_IDX_W-1:0] match_idx_q;
  logic                  free_found_q;
  logic [SLOT_IDX_W-1:0] free_idx_q;
  logic [MASK_W-1:0]     mask_q;
  logic [PEER_SLOTS-1:0] valid_q;

  // Result register.
  logic        out_valid_q;
  logic [4:0]  pid_q;
  logic [1:0]  status_q;
  logic        ack_q;
  logic [15:0] dlen_q;
  logic [15:0] emask_q;

  // Sequencer outputs.
  logic in_accept;
  logic rd_en;
  logic finish_go;

  // Memory interface.
  slot_ent_t             rd_ent;
  logic [$bits(slot_ent_t)-1:0] rd_raw;
  logic                  ram_we;
  logic [SLOT_IDX_W-1:0] ram_waddr;
  slot_ent_t             wr_ent;

  // Compare stage.
  logic                  slot_vld;
  logic                  hit;
  logic [31:0]           age;
  logic                  aged_out;
  logic                  expire;
  logic                  drop;
  logic [SLOT_IDX_W+3:0] cmp_idx_ext;

  // Finish-step result.
  logic [4:0]  res_pid;
  logic [1:0]  res_status;
  logic        res_ack;
  logic [15:0] res_dlen;
  logic        res_claim;

  psess_ram #(
    .WIDTH ($bits(slot_ent_t)),
    .DEPTH (PEER_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_ent),
    .re_i    (rd_en),
    .raddr_i (cnt_q),
    .rdata_o (rd_raw)
  );

  assign rd_ent = slot_ent_t'(rd_raw);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (cnt_q == SLOT_IDX_W'(PEER_SLOTS - 1)) state_d = S_LAST;
      end
      S_LAST: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    finish_go  = 1'b0;
    unique case (state_q)
      S_IDLE:   in_ready_o = 1'b1;
      S_SCAN:   rd_en      = 1'b1;
      S_LAST:   ;
      S_FINISH: finish_go  = !out_valid_q || out_ready_i;
      default:  ;
    endcase
  end

  assign in_accept = in_valid_i && in_ready_o;

  // Per-slot compare: key match, free search and aging in one pass. A slot that
  // is refreshed or disconnected by this event never ages out, and a slot that
  // a connect claims was free during the pass.
  always_comb begin
    slot_vld    = cmp_vld_q && valid_q[cmp_idx_q];
    hit         = slot_vld && !found_q && rd_ent.ip == ip_q && rd_ent.port == port_q;
    age         = now_q - rd_ent.last_heard;
    aged_out    = slot_vld && (age > timeout_q);
    expire      = aged_out && !(hit && (op_q == OP_HEARTBEAT || op_q == OP_DISCONNECT));
    drop        = expire || (hit && op_q == OP_DISCONNECT);
    cmp_idx_ext = {4'b0, cmp_idx_q};
  end

  // Event resolution and write-back.
  always_comb begin
    res_pid    = NO_PEER;
    res_status = ST_OK;
    res_ack    = 1'b0;
    res_dlen   = 16'd0;
    res_claim  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = match_idx_q;
    wr_ent     = '{ip: ip_q, port: port_q, last_heard: now_q};
    unique case (op_q)
      OP_CONNECT: begin
        if (found_q) begin
          res_status = ST_DUP;
        end else if (!free_found_q) begin
          res_status = ST_FULL;
        end else begin
          res_pid   = slot_to_pid(free_idx_q);
          res_ack   = 1'b1;
          res_claim = 1'b1;
          ram_we    = finish_go;
          ram_waddr = free_idx_q;
        end
      end
      OP_HEARTBEAT, OP_DISCONNECT, OP_DATA: begin
        if (!found_q) begin
          res_status = ST_UNKNOWN;
        end else begin
          res_pid = slot_to_pid(match_idx_q);
          if (op_q == OP_HEARTBEAT) ram_we = finish_go;
          if (op_q == OP_DATA) res_dlen = plen_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      timeout_q    <= TIMEOUT_RESET;
      cnt_q        <= '0;
      cmp_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= rd_en;
      if (cfg_we_i) timeout_q <= cfg_wdata_i;

      if (in_accept) begin
        cnt_q        <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else if (rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end

      if (cmp_vld_q) begin
        if (hit) found_q <= 1'b1;
        if (!valid_q[cmp_idx_q] && !free_found_q) free_found_q <= 1'b1;
        if (drop) valid_q[cmp_idx_q] <= 1'b0;
      end

      if (finish_go && res_claim) valid_q[free_idx_q] <= 1'b1;

      if (finish_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= op_i;
      ip_q   <= src_ip_i;
      port_q <= src_port_i;
      plen_q <= dgram_len_i;
      now_q  <= now_ms_i;
      mask_q <= '0;
    end
    cmp_idx_q <= cnt_q;
    if (cmp_vld_q) begin
      if (hit) match_idx_q <= cmp_idx_q;
      if (!valid_q[cmp_idx_q] && !free_found_q) free_idx_q <= cmp_idx_q;
      if (expire && cmp_idx_ext < (SLOT_IDX_W + 4)'(MASK_W)) mask_q[cmp_idx_ext[3:0]] <= 1'b1;
    end
    if (finish_go) begin
      pid_q    <= res_pid;
      status_q <= res_status;
      ack_q    <= res_ack;
      dlen_q   <= res_dlen;
      emask_q  <= mask_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign peer_id_o      = signed'(pid_q);
  assign status_o       = status_q;
  assign send_ack_o     = ack_q;
  assign rx_len_o       = dlen_q;
  assign expired_mask_o = emask_q;

`ifndef NO_ASSERTIONS
  // An acknowledgement only goes out with a claimed slot and an ok status.
  a_ack_claims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_ack_o |-> status_o == ST_OK && peer_id_o != signed'(NO_PEER))
    else $error("ack without a claimed slot");

  // A refused event never names a slot.
  a_refused_no_peer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> peer_id_o == signed'(NO_PEER) && !send_ack_o)
    else $error("refused event carries a slot");

  // Payload length is passed only for data from a known peer.
  a_dlen_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rx_len_o != 16'd0 |-> status_o == ST_OK && peer_id_o != signed'(NO_PEER))
    else $error("data length for unknown peer");

  // The memory is never written while a scan read is still in flight.
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q || rd_en |-> !ram_we)
    else $error("table write overlaps scan");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the peer session table core.
module tb_top
  import psess_pkg::*;
();

  // One classified event as presented on the input channel.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [15:0] dgram_len;
    logic [31:0] now_ms;
  } sess_event_t;

  // One result as it must appear on the output channel.
  typedef struct packed {
    logic signed [4:0] peer_id;
    logic [1:0]        status;
    logic              send_ack;
    logic [15:0]       rx_len;
    logic [MASK_W-1:0] expired_mask;
  } sess_result_t;

  // The tail wait is sized from the time an event spends in the core, with a
  // wide margin.
  localparam int unsigned DRAIN_CYCLES = 4 * (PEER_SLOTS + 3);
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned KEY_POOL     = 24;
  localparam int unsigned PHASE_EVENTS = 150;

  // Block inputs are known from time zero; reset starts asserted.
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [31:0]       cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic [2:0]        op_i          = OP_TICK;
  logic [31:0]       src_ip_i      = '0;
  logic [15:0]       src_port_i    = '0;
  logic [15:0]       dgram_len_i   = '0;
  logic [31:0]       now_ms_i      = '0;
  logic              out_ready_i   = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic signed [4:0] peer_id_o;
  logic [1:0]        status_o;
  logic              send_ack_o;
  logic [15:0]       rx_len_o;
  logic [15:0]       expired_mask_o;

  peer_session_table_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .src_ip_i       (src_ip_i),
    .src_port_i     (src_port_i),
    .dgram_len_i    (dgram_len_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .peer_id_o      (peer_id_o),
    .status_o       (status_o),
    .send_ack_o     (send_ack_o),
    .rx_len_o       (rx_len_o),
    .expired_mask_o (expired_mask_o)
  );

  always begin
    #5 clk_i = ~clk_i;
  end

  // Events waiting to be driven, and results owed by the core in order.
  sess_event_t  pending_events[$];
  sess_result_t expected_results[$];

  // Shadow copy of the session table and the timeout register.
  logic              shadow_valid [PEER_SLOTS];
  logic [31:0]       shadow_ip    [PEER_SLOTS];
  logic [15:0]       shadow_port  [PEER_SLOTS];
  logic [31:0]       shadow_heard [PEER_SLOTS];
  logic [31:0]       shadow_timeout = TIMEOUT_RESET;

  // Peer keys reused by the random events so that sessions actually build up.
  logic [31:0]       pool_ip   [KEY_POOL];
  logic [15:0]       pool_port [KEY_POOL];

  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  logic [31:0]       wall_ms       = '0;
  logic [31:0]       ms_step_max   = 32'd1;
  int unsigned       fail_count    = 0;
  int unsigned       cycle_count   = 0;
  sess_event_t       accepted_ev;
  sess_result_t      owed;

  initial begin
    for (int i = 0; i < PEER_SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_ip[i]    = '0;
      shadow_port[i]  = '0;
      shadow_heard[i] = '0;
    end
  end

  // Applies one event to the shadow table and returns the result the core must
  // produce. The event is applied first, then every live slot is aged, so a
  // slot claimed or refreshed by this very event has age zero and survives.
  function automatic sess_result_t session_predict(input sess_event_t ev);
    sess_result_t r;
    int           hit;
    int           free_slot;
    logic [31:0]  age;
    r.peer_id      = NO_PEER;
    r.status       = ST_OK;
    r.send_ack     = 1'b0;
    r.rx_len       = '0;
    r.expired_mask = '0;
    hit            = -1;
    free_slot      = -1;
    // Only live slots can match; a freed slot keeps its old key but is dead.
    for (int i = 0; i < PEER_SLOTS; i++) begin
      if (hit < 0 && shadow_valid[i] && shadow_ip[i] == ev.src_ip &&
          shadow_port[i] == ev.src_port) begin
        hit = i;
      end
      if (free_slot < 0 && !shadow_valid[i]) begin
        free_slot = i;
      end
    end
    case (ev.op)
      OP_CONNECT: begin
        if (hit >= 0) begin
          r.status = ST_DUP;
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          shadow_valid[free_slot] = 1'b1;
          shadow_ip[free_slot]    = ev.src_ip;
          shadow_port[free_slot]  = ev.src_port;
          shadow_heard[free_slot] = ev.now_ms;
          r.peer_id  = 5'(free_slot);
          r.send_ack = 1'b1;
        end
      end
      OP_HEARTBEAT, OP_DISCONNECT, OP_DATA: begin
        if (hit < 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          r.peer_id = 5'(hit);
          if (ev.op == OP_HEARTBEAT) begin
            shadow_heard[hit] = ev.now_ms;
          end else if (ev.op == OP_DISCONNECT) begin
            shadow_valid[hit] = 1'b0;
          end else begin
            r.rx_len = ev.dgram_len;
          end
        end
      end
      default: begin
        // A tick, or an unused op code, only drives the age sweep.
      end
    endcase
    // Ages wrap modulo 2^32, so an all-ones timeout can never be exceeded.
    for (int i = 0; i < PEER_SLOTS; i++) begin
      age = ev.now_ms - shadow_heard[i];
      if (shadow_valid[i] && age > shadow_timeout) begin
        shadow_valid[i] = 1'b0;
        if (i < MASK_W) begin
          r.expired_mask[i] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Input driver. The head of the pending queue is the event on the port while
  // valid is high; it is popped and predicted at the edge that accepts it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        accepted_ev = pending_events.pop_front();
        expected_results.push_back(session_predict(accepted_ev));
      end
      if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i  <= 1'b1;
        op_i        <= pending_events[0].op;
        src_ip_i    <= pending_events[0].src_ip;
        src_port_i  <= pending_events[0].src_port;
        dgram_len_i <= pending_events[0].dgram_len;
        now_ms_i    <= pending_events[0].now_ms;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor. Every accepted transaction is checked field by field
  // against the oldest owed result, and the ready line is redrawn each cycle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: peer_id %0d status %0d",
                 peer_id_o, status_o);
          fail_count++;
        end else begin
          owed = expected_results.pop_front();
          if (peer_id_o !== owed.peer_id) begin
            $error("peer_id: expected %0d, actual %0d", owed.peer_id, peer_id_o);
            fail_count++;
          end
          if (status_o !== owed.status) begin
            $error("status: expected %0d, actual %0d", owed.status, status_o);
            fail_count++;
          end
          if (send_ack_o !== owed.send_ack) begin
            $error("send_ack: expected %0d, actual %0d", owed.send_ack, send_ack_o);
            fail_count++;
          end
          if (rx_len_o !== owed.rx_len) begin
            $error("rx_len: expected %0d, actual %0d", owed.rx_len, rx_len_o);
            fail_count++;
          end
          if (expired_mask_o !== owed.expired_mask) begin
            $error("expired_mask: expected %h, actual %h", owed.expired_mask,
                   expired_mask_o);
            fail_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_event(input logic [2:0] op, input logic [31:0] ip,
                            input logic [15:0] port, input logic [15:0] plen,
                            input logic [31:0] now);
    sess_event_t ev;
    ev.op        = op;
    ev.src_ip    = ip;
    ev.src_port  = port;
    ev.dgram_len = plen;
    ev.now_ms    = now;
    pending_events.push_back(ev);
  endtask

  // Queues are only inspected at the falling edge, where both processes that
  // touch them are quiet.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_events.size() != 0 || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Builds a random event. Most events use the key pool and a clock that
  // advances in steps sized to the current timeout, so sessions are claimed,
  // refreshed and aged out; a few use unknown keys or jump the clock.
  function automatic sess_event_t random_event();
    sess_event_t ev;
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(99);
    if (pick < 30) begin
      ev.op = OP_CONNECT;
    end else if (pick < 55) begin
      ev.op = OP_HEARTBEAT;
    end else if (pick < 65) begin
      ev.op = OP_DISCONNECT;
    end else if (pick < 85) begin
      ev.op = OP_DATA;
    end else if (pick < 94) begin
      ev.op = OP_TICK;
    end else begin
      ev.op = 3'($urandom_range(7, 5));
    end
    if ($urandom_range(99) < 88) begin
      k           = $urandom_range(KEY_POOL - 1);
      ev.src_ip   = pool_ip[k];
      ev.src_port = pool_port[k];
    end else begin
      ev.src_ip   = $urandom;
      ev.src_port = 16'($urandom);
    end
    pick = $urandom_range(9);
    if (pick == 0) begin
      ev.dgram_len = '0;
    end else if (pick == 1) begin
      ev.dgram_len = '1;
    end else begin
      ev.dgram_len = 16'($urandom);
    end
    if ($urandom_range(99) < 3) begin
      wall_ms = $urandom;
    end else begin
      wall_ms = wall_ms + $urandom_range(ms_step_max);
    end
    ev.now_ms = wall_ms;
    return ev;
  endfunction

  // One random phase: with the core drained, write the timeout, set the idle
  // rates of both sides and queue a batch of random events.
  task automatic run_phase(input logic [31:0] idle_limit, input int unsigned send_pct,
                           input int unsigned recv_pct, input bit restart_clock,
                           input logic [31:0] start_ms);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i       <= 1'b1;
    cfg_wdata_i    <= idle_limit;
    shadow_timeout  = idle_limit;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    ms_step_max   = (idle_limit >> 2) + 32'd1;
    if (restart_clock) begin
      wall_ms = start_ms;
    end
    for (int i = 0; i < PHASE_EVENTS; i++) begin
      pending_events.push_back(random_event());
    end
  endtask

  initial begin
    // The pool holds the extreme keys, pairs that differ only in the port,
    // and random peers; there are more keys than slots so the table fills.
    pool_ip[0]   = '0;
    pool_port[0] = '0;
    pool_ip[1]   = '1;
    pool_port[1] = '1;
    pool_ip[2]   = '0;
    pool_port[2] = '1;
    pool_ip[3]   = '1;
    pool_port[3] = '0;
    for (int i = 4; i < KEY_POOL; i++) begin
      pool_ip[i]   = $urandom;
      pool_port[i] = 16'($urandom);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset timeout of 10000 ms.
    @(negedge clk_i);
    send_idle_pct = 37;
    recv_idle_pct = 72;
    // An unused op code behaves as a tick on an empty table.
    push_event(3'd7, '0, '0, '0, 32'd0);
    // First connect claims slot 0; the same key again is a duplicate.
    push_event(OP_CONNECT, '0, '0, '0, 32'd0);
    push_event(OP_CONNECT, '0, '0, '0, 32'd0);
    push_event(OP_CONNECT, '1, '1, '1, 32'd0);
    // Same address with another port is a different, unknown peer.
    push_event(OP_HEARTBEAT, '0, '1, '0, 32'd0);
    // Data from a known peer passes its length; from a stranger it is dropped.
    push_event(OP_DATA, '1, '1, '1, 32'd0);
    push_event(OP_DATA, 32'h0102_0304, 16'h0506, '1, 32'd0);
    // After a disconnect the freed slot must no longer match its old key.
    push_event(OP_DISCONNECT, '0, '0, '0, 32'd0);
    push_event(OP_DISCONNECT, '0, '0, '0, 32'd0);
    push_event(OP_HEARTBEAT, '0, '0, '0, 32'd0);
    // Fill every free slot, then one more connect finds the table full.
    for (int i = 0; i < PEER_SLOTS - 1; i++) begin
      push_event(OP_CONNECT, 32'(32'h0A00_0000 + i), 16'(1000 + i), '0, 32'd0);
    end
    push_event(OP_CONNECT, 32'h0B00_0000, 16'd2000, '0, 32'd0);
    // Refresh one peer, then age the rest to exactly the timeout (kept) and
    // one millisecond past it (all but the refreshed peer are dropped).
    push_event(OP_HEARTBEAT, '1, '1, '0, 32'd5000);
    push_event(3'd5, '0, '0, '0, 32'd10000);
    push_event(3'd6, '0, '0, '0, 32'd10001);
    wall_ms = 32'd10001;

    // Random phases. The receiver idles more than the sender at first, then
    // the other way round, then neither idles. The timeout walks through the
    // reset value, both extremes, short and medium settings, and one phase
    // starts just below the wrap of the millisecond clock.
    run_phase(TIMEOUT_RESET, 37, 72, 1'b0, '0);
    run_phase(32'hFFFF_FFFF, 37, 72, 1'b0, '0);
    run_phase(32'd0, 72, 37, 1'b0, '0);
    run_phase(32'd50, 72, 37, 1'b0, '0);
    run_phase(32'd1000, 0, 0, 1'b1, 32'hFFFF_F000);
    run_phase($urandom_range(20000, 1), 0, 0, 1'b0, '0);

    // Let any stray transaction show up before the verdict.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/psess_pkg.sv
rtl/psess_ram.sv
rtl/peer_session_table_core.sv
tb/tb_top.sv
